// ----- sv/stc_pkg.sv -----
// Shared constants and types for the shuffle table combiner.
// Depends on nothing. Used by stc_front, stc_queue, stc_back and the top level.
`default_nettype none

package stc_pkg;

  localparam int WORD_W      = 16;
  localparam int CFG_W       = 14;
  localparam int TABLE_DEPTH = 8192;
  localparam int STACK_DEPTH = 8192;
  localparam int Q_DEPTH     = 4;

  // Table index, and a width that can hold the table depth itself.
  localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USE_W  = $clog2(TABLE_DEPTH + 1);

  // Stack index and stack fill count.
  localparam int STK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW = $clog2(STACK_DEPTH + 1);

  localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  // Divider step counter.
  localparam int STEP_W = $clog2(WORD_W + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8192);

  typedef enum logic {
    OP_FILL = 1'b0,
    OP_SHUF = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TBL_AW-1:0] addr;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- sv/stc_front.sv -----
// Front end: accepts input beats, fills the table, keeps the word stacks and
// pairs an A word with a B word. Depends on stc_pkg.
`default_nettype none

module stc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [stc_pkg::WORD_W-1:0]    in_word,
  input  wire logic [stc_pkg::USE_W-1:0]     size_use,
  input  wire logic                          q_full,
  output logic                               q_wr_en,
  output stc_pkg::q_entry_t                  q_wr_data
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_POP  = 2'b10
  } f_state_t;

  f_state_t                      state_r, state_nxt;
  logic [stc_pkg::USE_W-1:0]     fill_cnt_r, fill_cnt_nxt;
  logic [stc_pkg::STK_CW-1:0]    stk_cnt_r, stk_cnt_nxt;
  logic                          stk_side_r, stk_side_nxt;
  logic [stc_pkg::WORD_W-1:0]    new_word_r, new_word_nxt;
  logic                          new_is_b_r, new_is_b_nxt;
  logic [stc_pkg::WORD_W-1:0]    stk_rd_r;
  logic [stc_pkg::STK_CW-1:0]    stk_top;
  logic                          stk_we, stk_re;
  logic [stc_pkg::STK_AW-1:0]    stk_addr;

  // Only one of the two stacks ever holds words, so they share one memory;
  // stk_side_r tells which stream the stored words came from.
  logic [stc_pkg::WORD_W-1:0] stk_mem [stc_pkg::STACK_DEPTH];

  assign stk_top = stk_cnt_r - 1'b1;

  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    stk_cnt_nxt  = stk_cnt_r;
    stk_side_nxt = stk_side_r;
    new_word_nxt = new_word_r;
    new_is_b_nxt = new_is_b_r;
    in_stall     = 1'b1;
    q_wr_en      = 1'b0;
    q_wr_data    = '0;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_addr     = stk_cnt_r[stc_pkg::STK_AW-1:0];
    case (state_r)
      F_IDLE: begin
        in_stall = q_full;
        if (in_valid && !q_full) begin
          if (!in_req_type && (fill_cnt_r < size_use)) begin
            q_wr_en          = 1'b1;
            q_wr_data.op     = stc_pkg::OP_FILL;
            q_wr_data.addr   = fill_cnt_r[stc_pkg::TBL_AW-1:0];
            q_wr_data.word_a = in_word;
            fill_cnt_nxt     = fill_cnt_r + 1'b1;
          end else if ((stk_cnt_r != '0) && (stk_side_r != in_req_type)) begin
            // The new word meets a word of the other stream: pop its top.
            stk_re       = 1'b1;
            stk_addr     = stk_top[stc_pkg::STK_AW-1:0];
            stk_cnt_nxt  = stk_top;
            new_word_nxt = in_word;
            new_is_b_nxt = in_req_type;
            state_nxt    = F_POP;
          end else if (stk_cnt_r < stc_pkg::STK_CW'(stc_pkg::STACK_DEPTH)) begin
            stk_we       = 1'b1;
            stk_cnt_nxt  = stk_cnt_r + 1'b1;
            stk_side_nxt = in_req_type;
          end
        end
      end
      F_POP: begin
        if (!q_full) begin
          q_wr_en          = 1'b1;
          q_wr_data.op     = stc_pkg::OP_SHUF;
          q_wr_data.word_a = new_is_b_r ? stk_rd_r : new_word_r;
          q_wr_data.word_b = new_is_b_r ? new_word_r : stk_rd_r;
          state_nxt        = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      fill_cnt_r <= '0;
      stk_cnt_r  <= '0;
      stk_side_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      stk_cnt_r  <= stk_cnt_nxt;
      stk_side_r <= stk_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_word_r <= new_word_nxt;
    new_is_b_r <= new_is_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= in_word;
    end
    if (stk_re) begin
      stk_rd_r <= stk_mem[stk_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/stc_queue.sv -----
// Short first-in first-out queue of table operations between front and back.
// Depends on stc_pkg.
`default_nettype none

module stc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire stc_pkg::q_entry_t wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output stc_pkg::q_entry_t      rd_data,
  output logic                   empty
);

  stc_pkg::q_entry_t            entry_r [stc_pkg::Q_DEPTH];
  logic [stc_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [stc_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [stc_pkg::Q_CW-1:0]     cnt_r, cnt_nxt;

  assign full    = (cnt_r == stc_pkg::Q_CW'(stc_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == stc_pkg::Q_AW'(stc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == stc_pkg::Q_AW'(stc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/stc_back.sv -----
// Back end: owns the shuffle table, reduces the B word modulo the table size
// with a bit-serial divider, swaps the entry and drives the result beat.
// Depends on stc_pkg.
`default_nettype none

module stc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [stc_pkg::USE_W-1:0]     size_use,
  input  wire logic                          q_empty,
  output logic                               q_rd_en,
  input  wire stc_pkg::q_entry_t             q_rd_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stc_pkg::WORD_W-1:0]         out_shuffled_word
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_DIV  = 4'b0010,
    B_RD   = 4'b0100,
    B_OUT  = 4'b1000
  } b_state_t;

  b_state_t                      state_r, state_nxt;
  logic [stc_pkg::USE_W-1:0]     rem_r, rem_nxt;
  logic [stc_pkg::WORD_W-1:0]    dvd_r, dvd_nxt;
  logic [stc_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [stc_pkg::WORD_W-1:0]    aw_r, aw_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [stc_pkg::WORD_W-1:0]    out_word_r, out_word_nxt;
  logic [stc_pkg::WORD_W-1:0]    tbl_rd_r;
  logic [stc_pkg::USE_W:0]       rem_sh, rem_sub, size_ext;
  logic [stc_pkg::USE_W-1:0]     rem_step;
  logic                          tbl_we, tbl_re;
  logic [stc_pkg::TBL_AW-1:0]    tbl_addr;
  logic [stc_pkg::WORD_W-1:0]    tbl_wdata;

  logic [stc_pkg::WORD_W-1:0] tbl_mem [stc_pkg::TABLE_DEPTH];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // The remainder stays below the size, so it always indexes the table.
  assign size_ext = {1'b0, size_use};
  assign rem_sh   = {rem_r, dvd_r[stc_pkg::WORD_W-1]};
  assign rem_sub  = rem_sh - size_ext;
  assign rem_step = (rem_sh >= size_ext) ? rem_sub[stc_pkg::USE_W-1:0]
                                         : rem_sh[stc_pkg::USE_W-1:0];

  assign out_valid         = out_valid_r;
  assign out_shuffled_word = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    step_nxt      = step_r;
    aw_nxt        = aw_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    q_rd_en       = 1'b0;
    tbl_we        = 1'b0;
    tbl_re        = 1'b0;
    tbl_addr      = rem_r[stc_pkg::TBL_AW-1:0];
    tbl_wdata     = aw_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_rd_en = 1'b1;
          if (q_rd_data.op == stc_pkg::OP_FILL) begin
            tbl_we    = 1'b1;
            tbl_addr  = q_rd_data.addr;
            tbl_wdata = q_rd_data.word_a;
          end else begin
            rem_nxt   = '0;
            dvd_nxt   = q_rd_data.word_b;
            aw_nxt    = q_rd_data.word_a;
            step_nxt  = stc_pkg::STEP_W'(stc_pkg::WORD_W);
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r - 1'b1;
        if (step_r == stc_pkg::STEP_W'(1)) begin
          state_nxt = B_RD;
        end
      end
      B_RD: begin
        // Read and write the same entry; the read returns the old word.
        tbl_we    = 1'b1;
        tbl_re    = 1'b1;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = tbl_rd_r;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    step_r     <= step_nxt;
    aw_r       <= aw_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rd_r <= tbl_mem[tbl_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/shuffle_table_combiner.sv -----
// A pairing beat's result passes the front end's stack read, the queue, the
// bit-serial divider steps, the table read/write and the output register.
// The back end works on one pair at a time and takes no new queue entry
// until its result is registered; fill and push beats are accepted back to back while the
// queue has room. Reset (synchronous, active low) clears counts, queue, state
// and table_size to 8192; table and stack contents are not cleared.
`default_nettype none

module shuffle_table_combiner (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [stc_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_req_type,
  input  wire logic [stc_pkg::WORD_W-1:0]    in_word,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stc_pkg::WORD_W-1:0]         out_shuffled_word
);

  logic [stc_pkg::CFG_W-1:0]  table_size_r;
  logic [stc_pkg::USE_W-1:0]  size_use;
  logic                       q_full, q_empty, q_wr_en, q_rd_en;
  stc_pkg::q_entry_t          q_wr_data, q_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= stc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // Size in use is the register clamped to one through the table depth.
  always_comb begin
    if (table_size_r == '0) begin
      size_use = stc_pkg::USE_W'(1);
    end else if (32'(table_size_r) > 32'(stc_pkg::TABLE_DEPTH)) begin
      size_use = stc_pkg::USE_W'(stc_pkg::TABLE_DEPTH);
    end else begin
      size_use = stc_pkg::USE_W'(table_size_r);
    end
  end

  stc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_word    (in_word),
    .size_use   (size_use),
    .q_full     (q_full),
    .q_wr_en    (q_wr_en),
    .q_wr_data  (q_wr_data)
  );

  stc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr_en),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd_en  (q_rd_en),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  stc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .size_use         (size_use),
    .q_empty          (q_empty),
    .q_rd_en          (q_rd_en),
    .q_rd_data        (q_rd_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_shuffled_word(out_shuffled_word)
  );

endmodule

`default_nettype wire

// ----- test/shuffle_table_combiner_tb.sv -----
// Self-checking testbench for shuffle_table_combiner: drives A and B word beats, predicts
// the displaced table words in a small tracker class and checks every result beat.
// Depends on stc_pkg and the shuffle_table_combiner RTL; reads no files.
`default_nettype none

module shuffle_table_combiner_tb;

  typedef enum bit {
    SRC_A = 1'b0,
    SRC_B = 1'b1
  } src_t;

  typedef enum int {
    MID_NONE,
    MID_HOLD,
    MID_PAUSE
  } mid_t;

  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 5000;

  class shuffle_tracker;
    bit [stc_pkg::WORD_W-1:0] table_words [stc_pkg::TABLE_DEPTH];
    bit [stc_pkg::WORD_W-1:0] a_words [stc_pkg::STACK_DEPTH];
    bit [stc_pkg::WORD_W-1:0] b_words [stc_pkg::STACK_DEPTH];
    int unsigned fill_count = 0;
    int unsigned a_count = 0;
    int unsigned b_count = 0;
    bit [stc_pkg::CFG_W-1:0] table_size = stc_pkg::CFG_RESET;
    bit [stc_pkg::WORD_W-1:0] displaced[$];
    int unsigned errors = 0;

    function int unsigned clamp_size(bit [stc_pkg::CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > stc_pkg::TABLE_DEPTH) return stc_pkg::TABLE_DEPTH;
      return 32'(v);
    endfunction

    // Growing the table past the filled part is only safe with stack A empty;
    // otherwise a pop could land on an entry that was never written.
    function bit fits_size(bit [stc_pkg::CFG_W-1:0] v);
      return a_count == 0 || clamp_size(v) <= fill_count;
    endfunction

    function void note_word(src_t src, bit [stc_pkg::WORD_W-1:0] w);
      int unsigned slot;
      bit [stc_pkg::WORD_W-1:0] a_top;
      bit [stc_pkg::WORD_W-1:0] b_top;
      if (src == SRC_A) begin
        if (fill_count < clamp_size(table_size)) begin
          table_words[fill_count] = w;
          fill_count++;
        end else if (a_count < stc_pkg::STACK_DEPTH) begin
          a_words[a_count] = w;
          a_count++;
        end
      end else if (b_count < stc_pkg::STACK_DEPTH) begin
        b_words[b_count] = w;
        b_count++;
      end
      if (a_count > 0 && b_count > 0) begin
        a_count--;
        b_count--;
        a_top = a_words[a_count];
        b_top = b_words[b_count];
        slot = b_top % clamp_size(table_size);
        displaced.insert(displaced.size(), table_words[slot]);
        table_words[slot] = a_top;
      end
    endfunction

    function void check_displaced(logic [stc_pkg::WORD_W-1:0] got);
      bit [stc_pkg::WORD_W-1:0] want;
      if (displaced.size() == 0) begin
        $error("shuffled_word: expected no beat, actual %h", got);
        errors++;
      end else begin
        want = displaced.pop_front();
        if (got !== want) begin
          $error("shuffled_word: expected %h, actual %h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [stc_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_req_type = 1'b0;
  logic [stc_pkg::WORD_W-1:0] in_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [stc_pkg::WORD_W-1:0] out_shuffled_word;

  shuffle_tracker tracker = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned quiet_cycles = 0;

  shuffle_table_combiner uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_shuffled_word(out_shuffled_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results are checked before inputs are noted; a beat accepted at this edge
  // cannot produce a result at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) tracker.check_displaced(out_shuffled_word);
      if (in_valid && in_stall === 1'b0) tracker.note_word(src_t'(in_req_type), in_word);
      if (cfg_we) tracker.table_size = cfg_wdata;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("shuffle_table_combiner_tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(src_t src, logic [stc_pkg::WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_req_type <= 1'($urandom_range(1));
      in_word <= stc_pkg::WORD_W'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= src;
    in_word <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.displaced.size() != 0) @(posedge clk);
  endtask

  // A beat that pairs nothing may still be in flight, so wait out the latency too.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic resize(logic [stc_pkg::CFG_W-1:0] v);
    settle();
    if (!tracker.fits_size(v)) v = stc_pkg::CFG_W'(tracker.fill_count);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [stc_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(4))
      0: return '0;
      1: return stc_pkg::CFG_W'(1);
      2: return stc_pkg::CFG_W'($urandom_range(2, 8));
      3: return stc_pkg::CFG_W'($urandom_range(9, 64));
      default: return stc_pkg::CFG_W'(tracker.fill_count);
    endcase
  endfunction

  task automatic random_phase(logic [stc_pkg::CFG_W-1:0] size, int items, int idle_p,
                              int stall_p, mid_t mid);
    int sent;
    int reps;
    src_t src;
    resize(size);
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    sent = 0;
    while (sent < items) begin
      if (sent >= items / 2 && mid != MID_NONE) begin
        if (mid == MID_HOLD) begin
          // Keep offering pairs while the receiver holds off, so the block backs up.
          holds_asked++;
          repeat (20) begin
            send_word(SRC_B, stc_pkg::WORD_W'($urandom));
            send_word(SRC_A, stc_pkg::WORD_W'($urandom));
          end
        end else begin
          drain_results();
        end
        mid = MID_NONE;
      end
      src = src_t'($urandom_range(1));
      reps = ($urandom_range(7) == 0) ? $urandom_range(2, 10) : 1;
      repeat (reps) send_word(src, stc_pkg::WORD_W'($urandom));
      sent += reps;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // At the reset size every A beat fills the table and B beats only stack up.
    send_word(SRC_A, 16'h0000);
    send_word(SRC_A, 16'hFFFF);
    send_word(SRC_A, 16'h8001);
    send_word(SRC_A, 16'h7FFE);
    send_word(SRC_B, 16'hFFFF);
    send_word(SRC_B, 16'h0000);
    send_word(SRC_B, 16'h0001);
    send_word(SRC_B, 16'h8000);
    // A size of zero acts as one, so every pair hits entry zero.
    resize('0);
    send_word(SRC_A, 16'h1234);
    send_word(SRC_A, 16'h4321);
    resize(stc_pkg::CFG_W'(4));
    send_word(SRC_A, 16'hABCD);
    send_word(SRC_A, 16'h1111);
    send_word(SRC_A, 16'h5555);
    send_word(SRC_B, 16'h0006);
    send_word(SRC_B, 16'h0007);
    send_word(SRC_B, 16'h0005);
    send_word(SRC_A, 16'h2222);
    send_word(SRC_A, 16'h3333);
    resize(stc_pkg::CFG_W'(1));
    send_word(SRC_A, 16'h6666);
    send_word(SRC_B, 16'hFFFE);

    // A small table fills quickly, so the pairs sent during the hold-off all pop.
    random_phase(stc_pkg::CFG_W'($urandom_range(2, 8)), 125, 0, 0, MID_HOLD);
    random_phase(pick_size(), 125, 49, 0, MID_PAUSE);
    random_phase(pick_size(), 125, 0, 49, MID_NONE);
    random_phase(pick_size(), 125, 18, 18, MID_NONE);

    settle();
    if (tracker.errors == 0) begin
      $display("shuffle_table_combiner_tb passed");
    end else begin
      $display("shuffle_table_combiner_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/stc_pkg.sv
sv/stc_front.sv
sv/stc_queue.sv
sv/stc_back.sv
sv/shuffle_table_combiner.sv
test/shuffle_table_combiner_tb.sv
